// File: sv/ps2_mouse_packet_cursor_defines.svh
// ----------------------------------------------------------------------------
// PS/2 mouse cursor assertion macros
// Shared concurrent assertion forms for the PS/2 mouse cursor block.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PS2MC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PS2MC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ps2mc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse cursor package
// Types and constants shared by the framer, the cursor unit and the top level.
// ----------------------------------------------------------------------------
package ps2mc_pkg;

    localparam int CoordBitsDef = 12;
    localparam int ScreenBits   = 13;
    localparam int MoveBits     = 9;

    localparam logic [ScreenBits-1:0] WidthReset  = 13'd1024;
    localparam logic [ScreenBits-1:0] HeightReset = 13'd768;
    localparam logic                  InvertReset = 1'b1;
    localparam logic                  EnableReset = 1'b0;

    localparam int PosResetX = 512;
    localparam int PosResetY = 384;

    // header byte bit positions
    localparam int HdrLeft  = 0;
    localparam int HdrRight = 1;
    localparam int HdrSync  = 3;
    localparam int HdrSignX = 4;
    localparam int HdrSignY = 5;
    localparam int HdrOvfX  = 6;
    localparam int HdrOvfY  = 7;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_INVERT = 2'd2,
        CFG_ENABLE = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        PH_HEAD = 3'b001,
        PH_XMOV = 3'b010,
        PH_YMOV = 3'b100
    } t_phase;

    typedef struct packed {
        logic                       valid;
        logic signed [MoveBits-1:0] dx;
        logic signed [MoveBits-1:0] dy;
        logic                       left;
        logic                       right;
    } t_pkt;

    typedef struct packed {
        logic [ScreenBits-1:0] width;
        logic [ScreenBits-1:0] height;
        logic                  invert;
    } t_view_cfg;

endpackage

// File: sv/ps2mc_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 byte channel
// Valid/ready channel carrying one controller byte and its source flag.
// ----------------------------------------------------------------------------
interface ps2mc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       from_aux;

    modport source (output valid, output data_byte, output from_aux, input ready);
    modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

// File: sv/ps2mc_cursor_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 cursor channel
// Valid/ready channel carrying cursor position and button state.
// ----------------------------------------------------------------------------
interface ps2mc_cursor_if #(
    parameter int COORD_BITS = ps2mc_pkg::CoordBitsDef
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic                  left_down;
    logic                  right_down;
    logic                  left_pressed;

    modport source (
        output valid, output cursor_x, output cursor_y, output left_down,
        output right_down, output left_pressed, input ready
    );
    modport sink (
        input valid, input cursor_x, input cursor_y, input left_down,
        input right_down, input left_pressed, output ready
    );
endinterface

// File: sv/ps2mc_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 packet framer
// Filters mouse bytes, frames three-byte packets and registers kept packets.
// ----------------------------------------------------------------------------
module ps2mc_framer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ps2mc_byte_if.sink          i_byte,
    input  logic                i_enable,
    input  logic                i_pkt_take,
    output ps2mc_pkg::t_pkt     o_pkt
);

    ps2mc_pkg::t_phase r_phase, n_phase;
    logic [7:0]        r_hdr, n_hdr;
    logic [7:0]        r_xmov, n_xmov;
    ps2mc_pkg::t_pkt   r_pkt, n_pkt;
    logic              w_accept;
    logic              w_mouse;

    assign i_byte.ready = !r_pkt.valid || i_pkt_take;
    assign w_accept     = i_byte.valid && i_byte.ready;
    assign w_mouse      = w_accept && i_enable && i_byte.from_aux;

    always_comb begin
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_xmov  = r_xmov;
        n_pkt   = r_pkt;
        if (i_pkt_take) begin
            n_pkt.valid = 1'b0;
        end
        if (w_mouse) begin
            case (r_phase)
                ps2mc_pkg::PH_XMOV: begin
                    n_xmov  = i_byte.data_byte;
                    n_phase = ps2mc_pkg::PH_YMOV;
                end
                ps2mc_pkg::PH_YMOV: begin
                    n_phase = ps2mc_pkg::PH_HEAD;
                    if (!r_hdr[ps2mc_pkg::HdrOvfX] && !r_hdr[ps2mc_pkg::HdrOvfY]) begin
                        n_pkt.valid = 1'b1;
                        n_pkt.dx    = $signed({r_hdr[ps2mc_pkg::HdrSignX], r_xmov});
                        n_pkt.dy    = $signed({r_hdr[ps2mc_pkg::HdrSignY],
                                               i_byte.data_byte});
                        n_pkt.left  = r_hdr[ps2mc_pkg::HdrLeft];
                        n_pkt.right = r_hdr[ps2mc_pkg::HdrRight];
                    end
                end
                default: begin
                    // header phase; resync until the always-one bit is seen
                    n_phase = ps2mc_pkg::PH_HEAD;
                    if (i_byte.data_byte[ps2mc_pkg::HdrSync]) begin
                        n_hdr   = i_byte.data_byte;
                        n_phase = ps2mc_pkg::PH_XMOV;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ps2mc_pkg::PH_HEAD;
            r_hdr   <= '0;
            r_xmov  <= '0;
            r_pkt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_xmov  <= n_xmov;
            r_pkt   <= n_pkt;
        end
    end

    assign o_pkt = r_pkt;

endmodule

// File: sv/ps2mc_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 cursor unit
// Applies a packet's movement, clamps to the screen and holds the result.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_cursor_defines.svh"

module ps2mc_cursor #(
    parameter int COORD_BITS = ps2mc_pkg::CoordBitsDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ps2mc_pkg::t_pkt      i_pkt,
    input  ps2mc_pkg::t_view_cfg i_cfg,
    output logic                 o_pkt_take,
    ps2mc_cursor_if.source       o_cursor
);

    localparam int SB   = ps2mc_pkg::ScreenBits;
    localparam int SumW = ((COORD_BITS > SB) ? COORD_BITS : SB) + 2;

    localparam logic signed [SumW-1:0] CoordMax =
        $signed(SumW'({COORD_BITS{1'b1}}));

    logic [COORD_BITS-1:0]   r_pos_x, n_pos_x;
    logic [COORD_BITS-1:0]   r_pos_y, n_pos_y;
    logic                    r_left, r_right, r_press;
    logic                    r_out_valid;
    logic signed [SumW-1:0]  w_sum_x, w_sum_y;
    logic signed [SumW-1:0]  w_pos_x, w_pos_y;
    logic signed [SumW-1:0]  w_dx, w_dy;

    function automatic logic [COORD_BITS-1:0] clamp_axis(
        input logic signed [SumW-1:0] v,
        input logic [SB-1:0]          size
    );
        logic [SB-1:0]          lim;
        logic signed [SumW-1:0] top;
        logic signed [SumW-1:0] res;
        lim = (size == '0) ? '0 : size - 1'b1;
        top = $signed(SumW'(lim));
        if (top > CoordMax) begin
            top = CoordMax;
        end
        if (v < 0) begin
            res = '0;
        end else if (v > top) begin
            res = top;
        end else begin
            res = v;
        end
        return res[COORD_BITS-1:0];
    endfunction

    assign o_pkt_take = i_pkt.valid && (!r_out_valid || o_cursor.ready);

    assign w_pos_x = $signed(SumW'(r_pos_x));
    assign w_pos_y = $signed(SumW'(r_pos_y));
    assign w_dx    = SumW'(i_pkt.dx);
    assign w_dy    = SumW'(i_pkt.dy);

    always_comb begin
        if (i_cfg.invert) begin
            w_sum_x = w_pos_x - w_dx;
            w_sum_y = w_pos_y + w_dy;
        end else begin
            w_sum_x = w_pos_x + w_dx;
            w_sum_y = w_pos_y - w_dy;
        end
        n_pos_x = clamp_axis(w_sum_x, i_cfg.width);
        n_pos_y = clamp_axis(w_sum_y, i_cfg.height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= COORD_BITS'(ps2mc_pkg::PosResetX);
            r_pos_y     <= COORD_BITS'(ps2mc_pkg::PosResetY);
            r_left      <= 1'b0;
            r_right     <= 1'b0;
            r_press     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pkt_take) begin
                r_pos_x     <= n_pos_x;
                r_pos_y     <= n_pos_y;
                r_left      <= i_pkt.left;
                r_right     <= i_pkt.right;
                r_press     <= i_pkt.left && !r_left;
                r_out_valid <= 1'b1;
            end else if (o_cursor.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cursor.valid        = r_out_valid;
    assign o_cursor.cursor_x     = r_pos_x;
    assign o_cursor.cursor_y     = r_pos_y;
    assign o_cursor.left_down    = r_left;
    assign o_cursor.right_down   = r_right;
    assign o_cursor.left_pressed = r_press;

    `PS2MC_ASSERT_NOW(a_press_has_left, i_clk, i_rst_n,
        o_cursor.valid && o_cursor.left_pressed, o_cursor.left_down,
        "left press without left down")
    `PS2MC_ASSERT_NEXT(a_x_on_screen, i_clk, i_rst_n,
        o_pkt_take && (i_cfg.width != '0),
        SumW'(r_pos_x) < SumW'($past(i_cfg.width)), "cursor x beyond screen")
    `PS2MC_ASSERT_NEXT(a_y_on_screen, i_clk, i_rst_n,
        o_pkt_take && (i_cfg.height != '0),
        SumW'(r_pos_y) < SumW'($past(i_cfg.height)), "cursor y beyond screen")

endmodule

// File: sv/ps2_mouse_packet_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor
// Frames PS/2 mouse packets and tracks a clamped screen cursor.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte takes one controller byte per request with its aux flag; bytes
//   that are not mouse data, and all bytes while disabled, are dropped.
//   Every third byte of a framed packet without overflow yields one
//   request on o_cursor with position and button state.
//   The configuration port writes screen width, height, invert and enable;
//   write it only while no packet is in flight.
// Timing:
//   One byte per cycle while i_byte is ready. The closing byte of a packet is
//   registered in the packet register, then the cursor add and clamp load
//   the result register from it.
// Reset:
//   Framing restarts at the header, cursor goes to 512,384, buttons clear,
//   registers take 1024x768, inverted axes, mouse disabled.
// Stall:
//   A held result blocks the packet register only; i_byte stays ready until
//   a second packet is waiting behind the held result.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor #(
    parameter int COORD_BITS = ps2mc_pkg::CoordBitsDef
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ps2mc_byte_if.sink                       i_byte,
    ps2mc_cursor_if.source                   o_cursor,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [ps2mc_pkg::ScreenBits-1:0] i_cfg_data
);

    logic [ps2mc_pkg::ScreenBits-1:0] r_width;
    logic [ps2mc_pkg::ScreenBits-1:0] r_height;
    logic                             r_invert;
    logic                             r_enable;
    ps2mc_pkg::t_pkt                  w_pkt;
    ps2mc_pkg::t_view_cfg             w_view;
    logic                             w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ps2mc_pkg::WidthReset;
            r_height <= ps2mc_pkg::HeightReset;
            r_invert <= ps2mc_pkg::InvertReset;
            r_enable <= ps2mc_pkg::EnableReset;
        end else if (i_cfg_we) begin
            case (ps2mc_pkg::t_cfg_reg'(i_cfg_idx))
                ps2mc_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                ps2mc_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                ps2mc_pkg::CFG_INVERT: r_invert <= i_cfg_data[0];
                ps2mc_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_view.width  = r_width;
    assign w_view.height = r_height;
    assign w_view.invert = r_invert;

    ps2mc_framer u_framer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_enable   (r_enable),
        .i_pkt_take (w_take),
        .o_pkt      (w_pkt)
    );

    ps2mc_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (w_pkt),
        .i_cfg      (w_view),
        .o_pkt_take (w_take),
        .o_cursor   (o_cursor)
    );

endmodule
